### hdl/l2n_pkg.sv
// Package for the L2 norm block: widths, queue entry and sequencer state types.
`default_nettype none
package l2n_pkg;

  localparam int ELEM_W  = 24;               // element width, Q8.16 signed
  localparam int SQ_W    = 2 * ELEM_W;       // exact square of a magnitude
  localparam int SUM_W   = 64;               // sum of squares, Q32.32
  localparam int NORM_W  = SUM_W / 2;        // root width, Q16.16 unsigned
  localparam int REM_W   = NORM_W + 2;       // partial remainder of the root
  localparam int CNT_W   = $clog2(NORM_W);   // root digit counter
  localparam int Q_DEPTH = 2;                // finished vectors held for the root
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  // One finished vector waiting for its root
  typedef struct packed {
    logic             sat;
    logic [SUM_W-1:0] sum;
  } vec_sum_t;

  // Queue status towards both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Root sequencer states
  typedef enum logic [1:0] {
    RT_IDLE,
    RT_CALC,
    RT_HOLD
  } rt_state_t;

endpackage
`default_nettype wire

### hdl/l2n_front.sv
// Front part: square each element and accumulate the saturating sum of squares.
`default_nettype none
module l2n_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [l2n_pkg::ELEM_W-1:0] in_element,
  input  wire logic                       in_last,
  input  wire l2n_pkg::q_stat_t           q_stat,
  output logic                            q_push,
  output l2n_pkg::vec_sum_t               q_wdata
);

  logic [l2n_pkg::ELEM_W-1:0] mag;
  logic [l2n_pkg::SQ_W-1:0]   sq_r;
  logic                       sq_vld_r;
  logic                       sq_last_r;
  logic [l2n_pkg::SUM_W-1:0]  sum_r;
  logic [l2n_pkg::SUM_W-1:0]  sum_nxt;
  logic                       sat_r;
  logic                       sat_nxt;
  logic [l2n_pkg::SUM_W:0]    sum_add;
  logic                       blocked;

  // Take the magnitude; the most negative code maps onto itself, read unsigned
  always_comb begin
    if (in_element[l2n_pkg::ELEM_W-1]) begin
      mag = ~in_element + l2n_pkg::ELEM_W'(1);
    end else begin
      mag = in_element;
    end
  end

  // Add with saturation at the top of the range
  always_comb begin
    sum_add = {1'b0, sum_r} + {{(l2n_pkg::SUM_W - l2n_pkg::SQ_W + 1){1'b0}}, sq_r};
    if (sum_add[l2n_pkg::SUM_W]) begin
      sum_nxt = {l2n_pkg::SUM_W{1'b1}};
    end else begin
      sum_nxt = sum_add[l2n_pkg::SUM_W-1:0];
    end
    sat_nxt = sat_r | sum_add[l2n_pkg::SUM_W];
  end

  // Hold the square stage while a finished vector has no queue slot
  assign blocked  = sq_vld_r & sq_last_r & q_stat.full;
  assign in_stall = blocked;
  assign q_push   = sq_vld_r & sq_last_r & ~blocked;
  assign q_wdata  = '{sat: sat_nxt, sum: sum_nxt};

  // Square stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (!blocked) begin
      sq_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!blocked && in_valid) begin
      sq_r      <= l2n_pkg::SQ_W'(mag) * l2n_pkg::SQ_W'(mag);
      sq_last_r <= in_last;
    end
  end

  // Accumulate; clear at the end of a vector
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sat_r <= 1'b0;
    end else if (sq_vld_r && !blocked) begin
      if (sq_last_r) begin
        sum_r <= '0;
        sat_r <= 1'b0;
      end else begin
        sum_r <= sum_nxt;
        sat_r <= sat_nxt;
      end
    end
  end

  // A saturated sum stays pinned at the top until the vector ends
  a_sat_pins_sum: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (sum_r == {l2n_pkg::SUM_W{1'b1}}))
    else $error("saturated flag set but sum not at full scale");

endmodule
`default_nettype wire

### hdl/l2n_fifo.sv
// Short queue of finished sums between the front and the root unit.
`default_nettype none
module l2n_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire l2n_pkg::vec_sum_t wdata,
  input  wire logic              pop,
  output l2n_pkg::vec_sum_t      rdata,
  output l2n_pkg::q_stat_t       stat
);

  l2n_pkg::vec_sum_t           mem_r [l2n_pkg::Q_DEPTH];
  logic [l2n_pkg::QPTR_W-1:0]  wptr_r;
  logic [l2n_pkg::QPTR_W-1:0]  rptr_r;
  logic [l2n_pkg::QCNT_W-1:0]  cnt_r;

  assign stat.full  = (cnt_r == l2n_pkg::QCNT_W'(l2n_pkg::Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rptr_r];

  // Write the entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + l2n_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + l2n_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + l2n_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - l2n_pkg::QCNT_W'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from an empty queue");

endmodule
`default_nettype wire

### hdl/l2n_sqrt.sv
// Back part: digit-by-digit floor square root and the result output register.
`default_nettype none
module l2n_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire l2n_pkg::q_stat_t            q_stat,
  input  wire l2n_pkg::vec_sum_t           q_rdata,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [l2n_pkg::NORM_W-1:0]       out_norm,
  output logic                             out_overflow
);

  l2n_pkg::rt_state_t           state_r;
  l2n_pkg::rt_state_t           state_nxt;
  logic [l2n_pkg::SUM_W-1:0]    x_r;
  logic [l2n_pkg::REM_W-1:0]    rem_r;
  logic [l2n_pkg::NORM_W-1:0]   root_r;
  logic [l2n_pkg::CNT_W-1:0]    cnt_r;
  logic                         sat_r;
  logic [l2n_pkg::REM_W-1:0]    rem_sh;
  logic [l2n_pkg::REM_W-1:0]    trial;
  logic                         ge;
  logic                         load_out;
  logic                         out_valid_r;
  logic [l2n_pkg::NORM_W-1:0]   out_norm_r;
  logic                         out_overflow_r;

  // One root digit: bring down two bits, try subtracting 4*root+1
  always_comb begin
    rem_sh = {rem_r[l2n_pkg::REM_W-3:0], x_r[l2n_pkg::SUM_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      l2n_pkg::RT_IDLE: if (!q_stat.empty) state_nxt = l2n_pkg::RT_CALC;
      l2n_pkg::RT_CALC: if (cnt_r == '0)   state_nxt = l2n_pkg::RT_HOLD;
      l2n_pkg::RT_HOLD: if (!out_valid_r || !out_stall) state_nxt = l2n_pkg::RT_IDLE;
      default:          state_nxt = l2n_pkg::RT_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      l2n_pkg::RT_IDLE: q_pop    = ~q_stat.empty;
      l2n_pkg::RT_CALC: ;
      l2n_pkg::RT_HOLD: load_out = ~out_valid_r | ~out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= l2n_pkg::RT_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Load a sum, then iterate one root bit per cycle
  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_r    <= q_rdata.sum;
      sat_r  <= q_rdata.sat;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= l2n_pkg::CNT_W'(l2n_pkg::NORM_W - 1);
    end else if (state_r == l2n_pkg::RT_CALC) begin
      x_r    <= {x_r[l2n_pkg::SUM_W-3:0], 2'b00};
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[l2n_pkg::NORM_W-2:0], ge};
      cnt_r  <= cnt_r - l2n_pkg::CNT_W'(1);
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_norm_r     <= root_r;
      out_overflow_r <= sat_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_norm     = out_norm_r;
  assign out_overflow = out_overflow_r;

  // Partial remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == l2n_pkg::RT_CALC) |-> (rem_r <= {1'b0, root_r, 1'b0}))
    else $error("root remainder out of range");

  a_calc_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == l2n_pkg::RT_CALC && cnt_r != '0) |=> (state_r == l2n_pkg::RT_CALC))
    else $error("root iteration left early");

endmodule
`default_nettype wire

### hdl/vector_l2_norm_core.sv
// Top level of the L2 norm block: front, queue and root unit.
//
// Usage:
//   Input channel (in_valid / in_stall / in_element / in_last) takes one
//   signed Q8.16 element per cycle unless stalled. Each element is squared
//   and added to a 64-bit sum of squares that saturates at full scale and
//   sets a flag. An element with in_last high ends the vector: its sum and
//   flag go into a two-entry queue and the accumulator clears for the next
//   vector. Result channel (out_valid / out_stall / out_norm / out_overflow)
//   gives one word per vector: the floor square root (Q16.16) and the flag.
// Timing:
//   Elements are taken at one per cycle while in_stall is low. The root
//   unit produces one root bit per cycle and pops a new sum from the
//   queue only once the previous result is loaded into the output register.
//   Vectors that end faster than roots are done fill the queue, and
//   in_stall then rises while a last element waits for a slot.
// Reset and stall:
//   rst_n (synchronous, active low) clears the sum, the flag, the queue and
//   the output register. While out_stall is high the result word holds; the
//   root unit and the queue keep the following vectors meanwhile.
`default_nettype none
module vector_l2_norm_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [l2n_pkg::ELEM_W-1:0]  in_element,
  input  wire logic                        in_last,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [l2n_pkg::NORM_W-1:0]       out_norm,
  output logic                             out_overflow
);

  l2n_pkg::q_stat_t  q_stat;
  l2n_pkg::vec_sum_t q_wdata;
  l2n_pkg::vec_sum_t q_rdata;
  logic              q_push;
  logic              q_pop;

  l2n_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_element (in_element),
    .in_last    (in_last),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_wdata    (q_wdata)
  );

  l2n_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  l2n_sqrt u_sqrt (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_norm     (out_norm),
    .out_overflow (out_overflow)
  );

endmodule
`default_nettype wire
